// ===== hdl/fdb_pkg.sv =====
package fdb_pkg;

    // fractional bits of the Q16.16 samples
    localparam int FRAC_BITS = 16;

    // noise constant after reset, Q0.16
    localparam logic [15:0] NOISE_K_RESET = 16'd655;

    // width of the configuration data port
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_FILTER_MODE = 1'b0,
        CFG_NOISE_K     = 1'b1
    } t_cfg_idx;

    // filter mode codes
    typedef enum logic [0:0] {
        MODE_WIENER  = 1'b0,
        MODE_INVERSE = 1'b1
    } t_mode;

    // control that travels down the pipeline with each beat
    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctl;

endpackage

// ===== hdl/frequency_deconvolution_bin_unit.sv =====
// per-bin wiener / inverse deconvolution
//
// channels: a bin is taken on each clock where start is high and busy is low;
// busy never rises, so a bin can enter every cycle. obs_* is the observed bin,
// psf_* the blur kernel bin, all signed Q16.16.
// results: o_valid is high for one cycle with o_rest_re / o_rest_im and the
// o_zero_divisor and o_saturated flags; there is no back pressure.
// pipeline: three front stages form products and sums, one stage checks
// quotient overflow, SAMPLE_WIDTH + 1 stages each give one quotient bit, and
// one stage saturates and signs the result.
// throughput: one bin per cycle, sustained.
// config: i_cfg_we writes i_cfg_wdata into register i_cfg_addr at once
// (0 filter mode, 1 noise k). Write only while no bin is in flight.
// reset: synchronous, active low; clears all valid bits, mode to wiener and
// noise k to 655.
module frequency_deconvolution_bin_unit #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_obs_re,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_obs_im,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_psf_re,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_psf_im,
    input  logic                              i_cfg_we,
    input  fdb_pkg::t_cfg_idx                 i_cfg_addr,
    input  logic [fdb_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output logic                              o_valid,
    output logic signed [SAMPLE_WIDTH-1:0]    o_rest_re,
    output logic signed [SAMPLE_WIDTH-1:0]    o_rest_im,
    output logic                              o_zero_divisor,
    output logic                              o_saturated
);
    import fdb_pkg::*;

    localparam int W = SAMPLE_WIDTH;

    logic [W-1:0] w_pos_max, w_neg_min;
    logic [W:0]   w_lim_pos, w_lim_neg;

    t_mode       r_mode;
    logic [15:0] r_noise_k;

    t_ctl         w_fctl, w_dctl, w_dctl_im;
    logic         w_neg_re, w_neg_im, w_dneg_re, w_dneg_im, w_ov_re, w_ov_im;
    logic [2*W:0] w_mag_re, w_mag_im, w_den;
    logic [W:0]   w_q_re, w_q_im;

    logic         n_sat_re, n_sat_im;
    logic [W-1:0] n_re, n_im;

    logic         r_valid, r_zero, r_sat;
    logic [W-1:0] r_re, r_im;

    assign busy = 1'b0;

    assign w_pos_max = {1'b0, {(W-1){1'b1}}};
    assign w_neg_min = {1'b1, {(W-1){1'b0}}};
    assign w_lim_pos = {2'b00, {(W-1){1'b1}}};
    assign w_lim_neg = {2'b01, {(W-1){1'b0}}};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_WIENER;
            r_noise_k <= NOISE_K_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FILTER_MODE: r_mode <= t_mode'(i_cfg_wdata[0]);
                CFG_NOISE_K:     r_noise_k <= i_cfg_wdata[15:0];
                default:         r_mode <= r_mode;
            endcase
        end
    end

    // products, numerator and divisor
    fdb_front #(.W(W)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start && !busy),
        .i_obs_re  (i_obs_re),
        .i_obs_im  (i_obs_im),
        .i_psf_re  (i_psf_re),
        .i_psf_im  (i_psf_im),
        .i_mode    (r_mode),
        .i_noise_k (r_noise_k),
        .o_ctl     (w_fctl),
        .o_neg_re  (w_neg_re),
        .o_neg_im  (w_neg_im),
        .o_mag_re  (w_mag_re),
        .o_mag_im  (w_mag_im),
        .o_den     (w_den)
    );

    // real and imaginary quotients
    fdb_div #(.W(W)) u_div_re (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_fctl),
        .i_neg   (w_neg_re),
        .i_mag   (w_mag_re),
        .i_den   (w_den),
        .o_ctl   (w_dctl),
        .o_neg   (w_dneg_re),
        .o_ov    (w_ov_re),
        .o_q     (w_q_re)
    );

    fdb_div #(.W(W)) u_div_im (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_fctl),
        .i_neg   (w_neg_im),
        .i_mag   (w_mag_im),
        .i_den   (w_den),
        .o_ctl   (w_dctl_im),
        .o_neg   (w_dneg_im),
        .o_ov    (w_ov_im),
        .o_q     (w_q_im)
    );

    // saturate and restore sign
    always_comb begin
        n_sat_re = w_ov_re || (w_q_re > (w_dneg_re ? w_lim_neg : w_lim_pos));
        n_sat_im = w_ov_im || (w_q_im > (w_dneg_im ? w_lim_neg : w_lim_pos));
        if (n_sat_re) begin
            n_re = w_dneg_re ? w_neg_min : w_pos_max;
        end else begin
            n_re = w_dneg_re ? (~w_q_re[W-1:0] + 1'b1) : w_q_re[W-1:0];
        end
        if (n_sat_im) begin
            n_im = w_dneg_im ? w_neg_min : w_pos_max;
        end else begin
            n_im = w_dneg_im ? (~w_q_im[W-1:0] + 1'b1) : w_q_im[W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_dctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero <= w_dctl.zero;
        r_sat  <= !w_dctl.zero && (n_sat_re || n_sat_im);
        r_re   <= w_dctl.zero ? '0 : n_re;
        r_im   <= w_dctl.zero ? '0 : n_im;
    end

    assign o_valid        = r_valid;
    assign o_rest_re      = r_re;
    assign o_rest_im      = r_im;
    assign o_zero_divisor = r_zero;
    assign o_saturated    = r_sat;

    // a zero divisor forces a zero result
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_divisor) |-> (o_rest_re == '0 && o_rest_im == '0))
        else $error("zero divisor with nonzero result");

    // the two flags never come together
    a_flag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_zero_divisor && o_saturated))
        else $error("zero divisor and saturation both set");

    // a clipped beat carries a range limit in one of its parts
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (r_re == w_pos_max || r_re == w_neg_min ||
             r_im == w_pos_max || r_im == w_neg_min))
        else $error("saturated beat without a limit value");

    // both dividers carry the same beat
    a_div_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dctl.valid == w_dctl_im.valid)
        else $error("dividers out of step");

endmodule

// ===== hdl/fdb_front.sv =====
module fdb_front #(
    parameter int W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [W-1:0]  i_obs_re,
    input  logic signed [W-1:0]  i_obs_im,
    input  logic signed [W-1:0]  i_psf_re,
    input  logic signed [W-1:0]  i_psf_im,
    input  fdb_pkg::t_mode       i_mode,
    input  logic [15:0]          i_noise_k,
    output fdb_pkg::t_ctl        o_ctl,
    output logic                 o_neg_re,
    output logic                 o_neg_im,
    output logic [2*W:0]         o_mag_re,
    output logic [2*W:0]         o_mag_im,
    output logic [2*W:0]         o_den
);
    import fdb_pkg::*;

    // stage 1: input registers
    logic                r_v1;
    logic signed [W-1:0] r_gr, r_gi, r_hr, r_hi;
    t_mode               r_mode1;
    logic [15:0]         r_k1;

    // stage 2: products
    logic                  r_v2;
    logic signed [2*W-1:0] r_prr, r_pii, r_pir, r_pri, r_srr, r_sii;
    t_mode                 r_mode2;
    logic [15:0]           r_k2;

    // stage 3: sums, magnitudes and divisor
    t_ctl         r_ctl3;
    logic         r_neg_re, r_neg_im;
    logic [2*W:0] r_mag_re, r_mag_im, r_den;

    logic signed [2*W:0] n_num_re, n_num_im;
    logic [2*W:0]        n_kext, n_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ctl3 <= '0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_ctl3.valid <= r_v2;
            r_ctl3.zero <= (n_den == '0);
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        r_gr <= i_obs_re;
        r_gi <= i_obs_im;
        r_hr <= i_psf_re;
        r_hi <= i_psf_im;
        r_mode1 <= i_mode;
        r_k1 <= i_noise_k;
    end

    // cross products and squares of the kernel bin
    always_ff @(posedge i_clk) begin
        r_prr <= r_gr * r_hr;
        r_pii <= r_gi * r_hi;
        r_pir <= r_gi * r_hr;
        r_pri <= r_gr * r_hi;
        r_srr <= r_hr * r_hr;
        r_sii <= r_hi * r_hi;
        r_mode2 <= r_mode1;
        r_k2 <= r_k1;
    end

    // numerator G*conj(H) and divisor |H|^2 (+ k in wiener mode)
    always_comb begin
        n_num_re = {r_prr[2*W-1], r_prr} + {r_pii[2*W-1], r_pii};
        n_num_im = {r_pir[2*W-1], r_pir} - {r_pri[2*W-1], r_pri};
        n_kext = (r_mode2 == MODE_WIENER)
               ? {{(2*W+1-16-FRAC_BITS){1'b0}}, r_k2, {FRAC_BITS{1'b0}}} : '0;
        n_den = {1'b0, $unsigned(r_srr)} + {1'b0, $unsigned(r_sii)} + n_kext;
    end

    always_ff @(posedge i_clk) begin
        r_neg_re <= n_num_re[2*W];
        r_neg_im <= n_num_im[2*W];
        r_mag_re <= n_num_re[2*W] ? $unsigned(-n_num_re) : $unsigned(n_num_re);
        r_mag_im <= n_num_im[2*W] ? $unsigned(-n_num_im) : $unsigned(n_num_im);
        r_den <= n_den;
    end

    assign o_ctl    = r_ctl3;
    assign o_neg_re = r_neg_re;
    assign o_neg_im = r_neg_im;
    assign o_mag_re = r_mag_re;
    assign o_mag_im = r_mag_im;
    assign o_den    = r_den;

endmodule

// ===== hdl/fdb_div.sv =====
module fdb_div #(
    parameter int W = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fdb_pkg::t_ctl i_ctl,
    input  logic          i_neg,
    input  logic [2*W:0]  i_mag,
    input  logic [2*W:0]  i_den,
    output fdb_pkg::t_ctl o_ctl,
    output logic          o_neg,
    output logic          o_ov,
    output logic [W:0]    o_q
);
    import fdb_pkg::*;

    localparam int RW = 2*W + 2;
    localparam int NW = 2*W + 1 + FRAC_BITS;
    localparam int NS = W + 1;

    logic [NW-1:0] w_num;
    logic [RW-1:0] w_rem0;

    t_ctl          r_ctl [0:NS];
    logic          r_neg [0:NS];
    logic          r_ov  [0:NS];
    logic [RW-1:0] r_rem [0:NS];
    logic [W:0]    r_low [0:NS];
    logic [W:0]    r_q   [0:NS];
    logic [2*W:0]  r_den [0:NS];

    // numerator scaled to Q.48, top part seeds the remainder
    assign w_num  = {i_mag, {FRAC_BITS{1'b0}}};
    assign w_rem0 = {{(RW-(NW-NS)){1'b0}}, w_num[NW-1:NS]};

    // entry stage: quotient overflow check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else begin
            r_ctl[0] <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg[0] <= i_neg;
        r_ov[0]  <= (w_rem0 >= {1'b0, i_den});
        r_rem[0] <= w_rem0;
        r_low[0] <= w_num[W:0];
        r_q[0]   <= '0;
        r_den[0] <= i_den;
    end

    // one quotient bit per stage, msb first
    for (genvar j = 1; j <= NS; j++) begin : g_stage
        logic [RW-1:0] w_trial;
        logic          w_ge;

        assign w_trial = {r_rem[j-1][RW-2:0], r_low[j-1][W]};
        assign w_ge    = (w_trial >= {1'b0, r_den[j-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[j] <= '0;
            end else begin
                r_ctl[j] <= r_ctl[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_neg[j] <= r_neg[j-1];
            r_ov[j]  <= r_ov[j-1];
            r_rem[j] <= w_ge ? (w_trial - {1'b0, r_den[j-1]}) : w_trial;
            r_low[j] <= {r_low[j-1][W-1:0], 1'b0};
            r_q[j]   <= {r_q[j-1][W-1:0], w_ge};
            r_den[j] <= r_den[j-1];
        end
    end

    assign o_ctl = r_ctl[NS];
    assign o_neg = r_neg[NS];
    assign o_ov  = r_ov[NS];
    assign o_q   = r_q[NS];

    // remainder stays below the divisor on every valid non-overflow beat
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl[NS].valid && !r_ctl[NS].zero && !r_ov[NS])
            |-> (r_rem[NS] < {1'b0, r_den[NS]}))
        else $error("remainder not below divisor");

    // zero divisor always reads as an overflow at entry
    a_zero_ov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl[0].valid && r_ctl[0].zero) |-> r_ov[0])
        else $error("zero divisor not caught");

    // control word moves one stage per cycle
    a_ctl_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[0].valid |=> r_ctl[1].valid)
        else $error("beat lost in divider");

endmodule

// ===== verif/tb.sv =====
module tb;
    import fdb_pkg::*;

    localparam int SW      = 32;
    localparam int LATENCY = SW + 6;
    localparam int WD_MAX  = 4000;

    typedef struct {
        logic signed [SW-1:0] re;
        logic signed [SW-1:0] im;
        logic                 zd;
        logic                 sat;
    } t_bin_res;

    typedef struct {
        t_mode                mode;
        logic [15:0]          k;
        logic signed [SW-1:0] g_re;
        logic signed [SW-1:0] g_im;
        logic signed [SW-1:0] h_re;
        logic signed [SW-1:0] h_im;
        bit                   typed;
        t_bin_res             res;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic signed [SW-1:0] i_obs_re, i_obs_im, i_psf_re, i_psf_im;
    logic                 i_cfg_we;
    t_cfg_idx             i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                 o_valid;
    logic signed [SW-1:0] o_rest_re, o_rest_im;
    logic                 o_zero_divisor, o_saturated;

    // configuration copy used by the predictor
    t_mode       cur_mode;
    logic [15:0] cur_k;

    t_bin_res restored_q[$];
    t_bin_res typed_res;
    bit       use_typed;
    int       err_cnt;
    int       idle_cnt;

    frequency_deconvolution_bin_unit #(.SAMPLE_WIDTH(SW)) DUT (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // one quotient part: truncate toward zero, then clip to the range
    function automatic logic signed [SW-1:0] scale_part(input logic signed [127:0] num,
                                                        input logic [127:0] den,
                                                        inout logic sat);
        logic [127:0] mag, q, lim;
        logic         neg;
        neg = num < 0;
        mag = neg ? -num : num;
        q   = (mag << FRAC_BITS) / den;
        lim = neg ? (128'd1 << (SW-1)) : ((128'd1 << (SW-1)) - 1);
        if (q > lim) begin
            q   = lim;
            sat = 1'b1;
        end
        return neg ? SW'(-q) : SW'(q);
    endfunction

    // restored bin G*conj(H) / (|H|^2 [+ k])
    function automatic t_bin_res deconv_bin(input logic signed [SW-1:0] gr, gi, hr, hi,
                                            input t_mode mode, input logic [15:0] k);
        t_bin_res r;
        logic signed [127:0] g_r, g_i, h_r, h_i, nre, nim;
        logic [127:0] den;
        logic sat;
        g_r = gr; g_i = gi; h_r = hr; h_i = hi;
        sat = 1'b0;
        den = h_r * h_r + h_i * h_i;
        if (mode == MODE_WIENER) den = den + ({112'd0, k} << FRAC_BITS);
        r = '{re: '0, im: '0, zd: 1'b0, sat: 1'b0};
        if (den == 0) begin
            r.zd = 1'b1;
            return r;
        end
        nre = g_r * h_r + g_i * h_i;
        nim = g_i * h_r - g_r * h_i;
        r.re  = scale_part(nre, den, sat);
        r.im  = scale_part(nim, den, sat);
        r.sat = sat;
        return r;
    endfunction

    // accept beats, predict and check results
    always @(posedge i_clk) begin
        t_bin_res exp_r;
        if (i_rst_n) begin
            if (start && !busy) begin
                if (use_typed) restored_q.push_back(typed_res);
                else restored_q.push_back(deconv_bin(i_obs_re, i_obs_im, i_psf_re,
                                                     i_psf_im, cur_mode, cur_k));
            end
            if (o_valid) begin
                if (restored_q.size() == 0) begin
                    $display("%0t: result with none expected: re %h im %h", $time,
                             o_rest_re, o_rest_im);
                    err_cnt++;
                end else begin
                    exp_r = restored_q.pop_front();
                    if (o_rest_re !== exp_r.re || o_rest_im !== exp_r.im ||
                        o_zero_divisor !== exp_r.zd || o_saturated !== exp_r.sat) begin
                        $display("%0t: expected re %h im %h zd %b sat %b, got re %h im %h zd %b sat %b",
                                 $time, exp_r.re, exp_r.im, exp_r.zd, exp_r.sat,
                                 o_rest_re, o_rest_im, o_zero_divisor, o_saturated);
                        err_cnt++;
                    end
                end
            end
            // watchdog on cycles with no bin accepted and no result
            if ((start && !busy) || o_valid) idle_cnt = 0;
            else idle_cnt++;
            if (idle_cnt >= WD_MAX) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // drain results, then let the pipeline settle
    task automatic wait_drained();
        while (restored_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_FILTER_MODE) cur_mode = t_mode'(val[0]);
        else cur_k = val;
    endtask

    task automatic set_filter(input t_mode mode, input logic [15:0] k);
        start = 1'b0;
        wait_drained();
        write_reg(CFG_FILTER_MODE, {15'($urandom_range(0, 32767)), mode});
        write_reg(CFG_NOISE_K, k);
    endtask

    // drive one beat, called at a falling edge
    task automatic send_bin(input logic signed [SW-1:0] gr, gi, hr, hi, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start    = 1'b1;
        i_obs_re = gr; i_obs_im = gi; i_psf_re = hr; i_psf_im = hi;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    function automatic logic signed [SW-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            2: begin
                case ($urandom_range(0, 4))
                    0:       return 32'sh7fffffff;
                    1:       return 32'sh80000000;
                    2:       return 0;
                    3:       return -1;
                    default: return 1;
                endcase
            end
            3:       return $signed($urandom_range(0, 1 << 23)) - (1 << 22);
            default: return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
        endcase
    endfunction

    t_row dir_tab[] = '{
        // after reset, all zero: wiener denominator is k alone
        '{MODE_WIENER, 16'd655, 0, 0, 0, 0, 1, '{0, 0, 0, 0}},
        '{MODE_WIENER, 16'd655, 32'sh7fffffff, 32'sh80000000, 0, 0, 1, '{0, 0, 0, 0}},
        '{MODE_WIENER, 16'd655, 32'sh00010000, 0, 32'sh00010000, 0, 0, '{0, 0, 0, 0}},
        '{MODE_WIENER, 16'd655, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
          0, '{0, 0, 0, 0}},
        '{MODE_WIENER, 16'd655, 32'sh80000000, 32'sh7fffffff, 1, -1, 0, '{0, 0, 0, 0}},
        // wiener with k zero, first with a zero kernel bin, then k at full scale
        '{MODE_WIENER, 16'd0, 32'sh12345678, -5, 0, 0, 1, '{0, 0, 1, 0}},
        '{MODE_WIENER, 16'd0, 32'sh00010000, 32'sh00010000, 32'sh00008000, 1, 0, '{0, 0, 0, 0}},
        '{MODE_WIENER, 16'hffff, 32'sh7fffffff, 32'sh80000000, 32'sh00010000, 32'sh7fffffff,
          0, '{0, 0, 0, 0}},
        '{MODE_WIENER, 16'hffff, -1, 1, -1, 1, 0, '{0, 0, 0, 0}},
        // inverse with zero kernel bin, then a unit kernel bin
        '{MODE_INVERSE, 16'd655, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 1, '{0, 0, 1, 0}},
        '{MODE_INVERSE, 16'd655, 32'sh00010000, 0, 32'sh00010000, 0, 1,
          '{32'sh00010000, 0, 0, 0}},
        // tiny kernel bin: clipped high and low
        '{MODE_INVERSE, 16'd655, 32'sh7fffffff, 0, 1, 0, 1, '{32'sh7fffffff, 0, 0, 1}},
        '{MODE_INVERSE, 16'd655, 32'sh80000000, 0, 1, 0, 1, '{32'sh80000000, 0, 0, 1}},
        '{MODE_INVERSE, 16'd655, 0, 32'sh7fffffff, 0, -1, 0, '{0, 0, 0, 0}},
        '{MODE_INVERSE, 16'd655, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
          0, '{0, 0, 0, 0}},
        '{MODE_INVERSE, 16'd655, -7, 3, 32'sh7fffffff, 32'sh80000000, 0, '{0, 0, 0, 0}},
        '{MODE_INVERSE, 16'd655, 32'sh00030000, -32'sh00020000, 32'sh00000100, 32'sh00000080,
          0, '{0, 0, 0, 0}}
    };

    initial begin
        t_mode       mode_set [3] = '{MODE_WIENER, MODE_INVERSE, MODE_WIENER};
        logic [15:0] k_set [4]    = '{16'd0, 16'hffff, 16'd655, 16'd1};
        int          idle_set [3] = '{34, 75, 0};
        start       = 1'b0;
        i_rst_n     = 1'b0;
        i_obs_re    = '0; i_obs_im = '0; i_psf_re = '0; i_psf_im = '0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = CFG_FILTER_MODE;
        i_cfg_wdata = '0;
        cur_mode    = MODE_WIENER;
        cur_k       = NOISE_K_RESET;
        use_typed   = 1'b0;
        err_cnt     = 0;
        idle_cnt    = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows
        foreach (dir_tab[i]) begin
            if (dir_tab[i].mode != cur_mode || dir_tab[i].k != cur_k)
                set_filter(dir_tab[i].mode, dir_tab[i].k);
            use_typed = dir_tab[i].typed;
            typed_res = dir_tab[i].res;
            send_bin(dir_tab[i].g_re, dir_tab[i].g_im, dir_tab[i].h_re, dir_tab[i].h_im,
                     $urandom_range(0, 1) * 40);
        end
        use_typed = 1'b0;

        // random bins, one idle profile and several filter settings per phase
        for (int ph = 0; ph < 3; ph++) begin
            for (int sub = 0; sub < 4; sub++) begin
                set_filter(sub == 3 ? MODE_INVERSE : mode_set[ph], k_set[(sub + ph) % 4]);
                for (int n = 0; n < 150; n++) begin
                    // mid-phase hold-off until every result is back
                    if (sub == 1 && n == 75) begin
                        start = 1'b0;
                        while (restored_q.size() != 0) @(negedge i_clk);
                    end
                    send_bin(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                             (n % 50 < 10) ? 0 : idle_set[ph]);
                end
            end
        end

        start = 1'b0;
        wait_drained();
        if (err_cnt == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule
